// ===== src/vector3_arith_unit_core_defines.svh =====
`ifndef VECTOR3_ARITH_UNIT_CORE_DEFINES_SVH
`define VECTOR3_ARITH_UNIT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define V3AU_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define V3AU_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/v3au_pkg.sv =====
package v3au_pkg;

	localparam int CMD_W = 4;

	localparam logic [CMD_W-1:0] CMD_ADD       = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB       = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SCALE     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DIVIDE    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DOT       = 4'd4;
	localparam logic [CMD_W-1:0] CMD_CROSS     = 4'd5;
	localparam logic [CMD_W-1:0] CMD_LENGTH    = 4'd6;
	localparam logic [CMD_W-1:0] CMD_NORMALIZE = 4'd7;
	localparam logic [CMD_W-1:0] CMD_EQUAL     = 4'd8;

	// travels alongside every transaction through the pipeline
	typedef struct packed {
		logic             vld;
		logic [CMD_W-1:0] cmd;
	} ctl_t;

endpackage

// ===== src/v3au_sqrt_cell.sv =====
`include "vector3_arith_unit_core_defines.svh"

module v3au_sqrt_cell #(
	parameter int RW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  v3au_pkg::ctl_t    ctl_in,
	input  logic [2*RW-1:0]   x_in,
	input  logic [RW+1:0]     rem_in,
	input  logic [RW-1:0]     root_in,
	output v3au_pkg::ctl_t    ctl_out,
	output logic [2*RW-1:0]   x_out,
	output logic [RW+1:0]     rem_out,
	output logic [RW-1:0]     root_out
);
	import v3au_pkg::*;

	ctl_t            ctl_q;
	logic [2*RW-1:0] x_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;

	logic [RW+3:0]   t;
	logic [RW+3:0]   trial;
	logic            ge;
	logic [RW+1:0]   rem_nx;

	// one root bit per cell: bring down two radicand bits, try (root << 2) | 1
	always_comb begin
		t      = {rem_in, x_in[2*RW-1 -: 2]};
		trial  = {2'b00, root_in, 2'b01};
		ge     = (t >= trial);
		rem_nx = ge ? (RW+2)'(t - trial) : t[RW+1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= {x_in[2*RW-3:0], 2'b00};
		rem_q  <= rem_nx;
		root_q <= {root_in[RW-2:0], ge};
	end

	assign ctl_out  = ctl_q;
	assign x_out    = x_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

	`V3AU_CHECK(a_sqrt_rem_bound, ctl_q.vld, rem_q <= {1'b0, root_q, 1'b0}, "sqrt remainder above twice the partial root")

endmodule

// ===== src/v3au_div_cell.sv =====
`include "vector3_arith_unit_core_defines.svh"

module v3au_div_cell #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  v3au_pkg::ctl_t       ctl_in,
	input  logic [DW-1:0]        dvs_in,
	input  logic [2:0][DW-1:0]   rem_in,
	input  logic [2:0][NW-1:0]   nq_in,
	output v3au_pkg::ctl_t       ctl_out,
	output logic [DW-1:0]        dvs_out,
	output logic [2:0][DW-1:0]   rem_out,
	output logic [2:0][NW-1:0]   nq_out
);
	import v3au_pkg::*;

	ctl_t               ctl_q;
	logic [DW-1:0]      dvs_q;
	logic [2:0][DW-1:0] rem_q;
	logic [2:0][NW-1:0] nq_q;

	logic [2:0][DW:0]   t;
	logic [2:0]         ge;
	logic [2:0][DW-1:0] rem_nx;
	logic [2:0][NW-1:0] nq_nx;

	// restoring step on three lanes; dividend bits leave at the top of nq,
	// quotient bits enter at the bottom
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i]      = {rem_in[i], nq_in[i][NW-1]};
			ge[i]     = (t[i] >= {1'b0, dvs_in});
			rem_nx[i] = ge[i] ? DW'(t[i] - {1'b0, dvs_in}) : t[i][DW-1:0];
			nq_nx[i]  = {nq_in[i][NW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		dvs_q <= dvs_in;
		rem_q <= rem_nx;
		nq_q  <= nq_nx;
	end

	assign ctl_out = ctl_q;
	assign dvs_out = dvs_q;
	assign rem_out = rem_q;
	assign nq_out  = nq_q;

	`V3AU_CHECK(a_div_rem_bound, ctl_q.vld && (dvs_q != '0), rem_q[0] < dvs_q, "division remainder not below divisor")

endmodule

// ===== src/vector3_arith_unit_core.sv =====
// 3-component vector arithmetic unit, signed fixed point (Q16.16 by default).
// Input channel: command, a_x/a_y/a_z, b_x/b_y/b_z and scalar_in are taken
// as one transaction at a rising edge with start high and busy low. busy is
// never raised, so a new transaction can be started in every cycle.
// Output channel: done is high for exactly one cycle together with res_x,
// res_y, res_z, res_scalar, is_equal and fault; one result per transaction,
// in order of acceptance.
// Throughput is one transaction per cycle. The latency is set by the
// square-root cell row (one root bit per cell, COMP_WIDTH cells) followed
// by the divider cell row (one quotient bit per cell, COMP_WIDTH +
// FRAC_BITS cells); every command passes both rows.
// Reset clears all valid flags at once; results in flight are dropped and no
// done is raised until a new transaction has gone through.
// The receiver cannot stall: a result is gone after its done cycle.
`include "vector3_arith_unit_core_defines.svh"

module vector3_arith_unit_core #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [v3au_pkg::CMD_W-1:0]   command,
	input  logic signed [COMP_WIDTH-1:0] a_x,
	input  logic signed [COMP_WIDTH-1:0] a_y,
	input  logic signed [COMP_WIDTH-1:0] a_z,
	input  logic signed [COMP_WIDTH-1:0] b_x,
	input  logic signed [COMP_WIDTH-1:0] b_y,
	input  logic signed [COMP_WIDTH-1:0] b_z,
	input  logic signed [COMP_WIDTH-1:0] scalar_in,
	output logic                         done,
	output logic signed [COMP_WIDTH-1:0] res_x,
	output logic signed [COMP_WIDTH-1:0] res_y,
	output logic signed [COMP_WIDTH-1:0] res_z,
	output logic signed [COMP_WIDTH-1:0] res_scalar,
	output logic                         is_equal,
	output logic                         fault
);
	import v3au_pkg::*;

	localparam int W       = COMP_WIDTH;
	localparam int F       = FRAC_BITS;
	localparam int PW      = 2 * W;
	localparam int NW      = W + F;
	localparam int EW      = ((PW > NW) ? PW : NW) + 2;
	localparam int CHK_LAG = W + NW + 5;

	localparam logic signed [EW-1:0] VMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN_E = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W-1:0]         VMAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]         VMIN_W = {1'b1, {(W-1){1'b0}}};

	function automatic logic [W-1:0] sat_w(input logic signed [EW-1:0] v);
		logic [W-1:0] r;
		if (v > VMAX_E) begin
			r = VMAX_W;
		end else if (v < VMIN_E) begin
			r = VMIN_W;
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	// ---------------- input register
	ctl_t                ctl_s1;
	logic signed [W-1:0] a_s1 [3];
	logic signed [W-1:0] b_s1 [3];
	logic signed [W-1:0] k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld <= start && !busy;
			ctl_s1.cmd <= command;
		end
	end

	always_ff @(posedge clk) begin
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
		k_s1    <= scalar_in;
	end

	// ---------------- products
	logic signed [W-1:0] op_l [6];
	logic signed [W-1:0] op_r [6];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			op_l[i]   = a_s1[i];
			op_r[i]   = b_s1[i];
			op_l[i+3] = '0;
			op_r[i+3] = '0;
		end
		case (ctl_s1.cmd)
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					op_r[i] = k_s1;
				end
			end
			CMD_CROSS: begin
				op_l[0] = a_s1[1]; op_r[0] = b_s1[2];
				op_l[1] = a_s1[2]; op_r[1] = b_s1[1];
				op_l[2] = a_s1[2]; op_r[2] = b_s1[0];
				op_l[3] = a_s1[0]; op_r[3] = b_s1[2];
				op_l[4] = a_s1[0]; op_r[4] = b_s1[1];
				op_l[5] = a_s1[1]; op_r[5] = b_s1[0];
			end
			CMD_LENGTH, CMD_NORMALIZE: begin
				for (int i = 0; i < 3; i++) begin
					op_r[i] = a_s1[i];
				end
			end
			default: begin
			end
		endcase
	end

	ctl_t                 ctl_s2;
	logic signed [PW-1:0] prod_s2 [6];
	logic signed [W-1:0]  a_s2 [3];
	logic signed [W-1:0]  b_s2 [3];
	logic signed [W-1:0]  k_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			prod_s2[i] <= PW'(op_l[i]) * PW'(op_r[i]);
		end
		for (int i = 0; i < 3; i++) begin
			a_s2[i] <= a_s1[i];
			b_s2[i] <= b_s1[i];
		end
		k_s2 <= k_s1;
	end

	// ---------------- sums, truncating shifts and saturation of the direct commands
	logic [W-1:0]  early_vec [3];
	logic [W-1:0]  early_scl;
	logic          early_eq;
	logic [PW-1:0] sq_sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			early_vec[i] = '0;
		end
		early_scl = '0;
		early_eq  = 1'b0;
		sq_sum    = $unsigned(prod_s2[0]) + $unsigned(prod_s2[1]) + $unsigned(prod_s2[2]);
		case (ctl_s2.cmd)
			CMD_ADD: begin
				for (int i = 0; i < 3; i++) begin
					early_vec[i] = sat_w(EW'(a_s2[i]) + EW'(b_s2[i]));
				end
			end
			CMD_SUB: begin
				for (int i = 0; i < 3; i++) begin
					early_vec[i] = sat_w(EW'(a_s2[i]) - EW'(b_s2[i]));
				end
			end
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					early_vec[i] = sat_w(EW'(prod_s2[i]) >>> F);
				end
			end
			CMD_DOT: begin
				early_scl = sat_w((EW'(prod_s2[0]) + EW'(prod_s2[1]) + EW'(prod_s2[2])) >>> F);
			end
			CMD_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					early_vec[i] = sat_w((EW'(prod_s2[2*i]) - EW'(prod_s2[2*i+1])) >>> F);
				end
			end
			CMD_EQUAL: begin
				early_eq = (a_s2[0] == b_s2[0]) && (a_s2[1] == b_s2[1]) &&
					(a_s2[2] == b_s2[2]);
			end
			default: begin
			end
		endcase
	end

	ctl_t          ctl_s3;
	logic [PW-1:0] sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	// side line that keeps pace with the square-root cells
	logic [W-1:0]        sl_vec_q [W+1][3];
	logic [W-1:0]        sl_scl_q [W+1];
	logic                sl_eq_q  [W+1];
	logic signed [W-1:0] sl_a_q   [W+1][3];
	logic signed [W-1:0] sl_k_q   [W+1];

	always_ff @(posedge clk) begin
		sq_s3 <= sq_sum;
		for (int i = 0; i < 3; i++) begin
			sl_vec_q[0][i] <= early_vec[i];
			sl_a_q[0][i]   <= a_s2[i];
		end
		sl_scl_q[0] <= early_scl;
		sl_eq_q[0]  <= early_eq;
		sl_k_q[0]   <= k_s2;
		for (int j = 1; j <= W; j++) begin
			sl_vec_q[j] <= sl_vec_q[j-1];
			sl_a_q[j]   <= sl_a_q[j-1];
			sl_scl_q[j] <= sl_scl_q[j-1];
			sl_eq_q[j]  <= sl_eq_q[j-1];
			sl_k_q[j]   <= sl_k_q[j-1];
		end
	end

	// ---------------- square-root cell row
	ctl_t          sctl  [W+1];
	logic [PW-1:0] sx    [W+1];
	logic [W+1:0]  srem  [W+1];
	logic [W-1:0]  sroot [W+1];

	assign sctl[0]  = ctl_s3;
	assign sx[0]    = sq_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	for (genvar j = 0; j < W; j++) begin : g_sqrt
		v3au_sqrt_cell #(
			.RW (W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (sctl[j]),
			.x_in     (sx[j]),
			.rem_in   (srem[j]),
			.root_in  (sroot[j]),
			.ctl_out  (sctl[j+1]),
			.x_out    (sx[j+1]),
			.rem_out  (srem[j+1]),
			.root_out (sroot[j+1])
		);
	end

	// ---------------- divider set-up
	logic               is_div;
	logic               set_flt;
	logic [W-1:0]       set_dvs;
	logic [2:0][NW-1:0] set_nq;
	logic [2:0]         set_neg;
	logic [W-1:0]       set_scl;

	always_comb begin
		is_div  = (sctl[W].cmd == CMD_DIVIDE);
		set_flt = (is_div && (sl_k_q[W] == '0)) ||
			((sctl[W].cmd == CMD_NORMALIZE) && (sroot[W] == '0));
		set_dvs = is_div ? mag_w(sl_k_q[W]) : sroot[W];
		for (int i = 0; i < 3; i++) begin
			set_nq[i]  = {mag_w(sl_a_q[W][i]), {F{1'b0}}};
			set_neg[i] = sl_a_q[W][i][W-1] ^ (is_div & sl_k_q[W][W-1]);
		end
		// length and normalize both report the saturated root
		if (sctl[W].cmd inside {CMD_LENGTH, CMD_NORMALIZE}) begin
			set_scl = sroot[W][W-1] ? VMAX_W : sroot[W];
		end else begin
			set_scl = sl_scl_q[W];
		end
	end

	ctl_t               ctl_s4;
	logic [W-1:0]       dvs_s4;
	logic [2:0][NW-1:0] nq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= sctl[W];
		end
	end

	// side line that keeps pace with the divider cells
	logic [W-1:0] dl_vec_q [NW+1][3];
	logic [W-1:0] dl_scl_q [NW+1];
	logic         dl_eq_q  [NW+1];
	logic [2:0]   dl_neg_q [NW+1];
	logic         dl_flt_q [NW+1];

	always_ff @(posedge clk) begin
		dvs_s4 <= set_dvs;
		nq_s4  <= set_nq;
		for (int i = 0; i < 3; i++) begin
			dl_vec_q[0][i] <= sl_vec_q[W][i];
		end
		dl_scl_q[0] <= set_scl;
		dl_eq_q[0]  <= sl_eq_q[W];
		dl_neg_q[0] <= set_neg;
		dl_flt_q[0] <= set_flt;
		for (int j = 1; j <= NW; j++) begin
			dl_vec_q[j] <= dl_vec_q[j-1];
			dl_scl_q[j] <= dl_scl_q[j-1];
			dl_eq_q[j]  <= dl_eq_q[j-1];
			dl_neg_q[j] <= dl_neg_q[j-1];
			dl_flt_q[j] <= dl_flt_q[j-1];
		end
	end

	// ---------------- divider cell row
	ctl_t               dctl [NW+1];
	logic [W-1:0]       ddvs [NW+1];
	logic [2:0][W-1:0]  drem [NW+1];
	logic [2:0][NW-1:0] dnq  [NW+1];

	assign dctl[0] = ctl_s4;
	assign ddvs[0] = dvs_s4;
	assign drem[0] = '0;
	assign dnq[0]  = nq_s4;

	for (genvar j = 0; j < NW; j++) begin : g_div
		v3au_div_cell #(
			.NW (NW),
			.DW (W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (dctl[j]),
			.dvs_in  (ddvs[j]),
			.rem_in  (drem[j]),
			.nq_in   (dnq[j]),
			.ctl_out (dctl[j+1]),
			.dvs_out (ddvs[j+1]),
			.rem_out (drem[j+1]),
			.nq_out  (dnq[j+1])
		);
	end

	// ---------------- sign, saturation and result selection
	logic signed [EW-1:0] qv [3];
	logic [W-1:0]         fin_vec [3];
	logic [W-1:0]         fin_scl;
	logic                 fin_eq;
	logic                 fin_flt;
	logic                 uses_div;

	always_comb begin
		uses_div = (dctl[NW].cmd == CMD_DIVIDE) || (dctl[NW].cmd == CMD_NORMALIZE);
		fin_flt  = uses_div && dl_flt_q[NW];
		fin_eq   = dl_eq_q[NW];
		fin_scl  = fin_flt ? '0 : dl_scl_q[NW];
		for (int i = 0; i < 3; i++) begin
			qv[i] = $signed({{(EW-NW){1'b0}}, dnq[NW][i]});
			if (dl_neg_q[NW][i]) begin
				qv[i] = -qv[i];
			end
			if (fin_flt) begin
				fin_vec[i] = '0;
			end else if (uses_div) begin
				fin_vec[i] = sat_w(qv[i]);
			end else begin
				fin_vec[i] = dl_vec_q[NW][i];
			end
		end
	end

	logic         done_q;
	logic [W-1:0] res_q [3];
	logic [W-1:0] scl_q;
	logic         eq_q;
	logic         flt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dctl[NW].vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			res_q[i] <= fin_vec[i];
		end
		scl_q <= fin_scl;
		eq_q  <= fin_eq;
		flt_q <= fin_flt;
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign res_x      = res_q[0];
	assign res_y      = res_q[1];
	assign res_z      = res_q[2];
	assign res_scalar = scl_q;
	assign is_equal   = eq_q;
	assign fault      = flt_q;

	`V3AU_CHECK(a_done_follows_start, done, $past(start && !busy, CHK_LAG), "result without a matching transaction")
	`V3AU_CHECK(a_fault_zeroes, done && fault, (res_x == '0) && (res_y == '0) && (res_z == '0) && (res_scalar == '0) && !is_equal, "fault with non-zero result fields")
	`V3AU_CHECK_NEXT(a_fault_only_div, dctl[NW].vld && (dctl[NW].cmd != CMD_DIVIDE) && (dctl[NW].cmd != CMD_NORMALIZE), !fault, "fault raised outside divide and normalize")

endmodule

// ===== tb/vector3_arith_unit_core_test.sv =====
`timescale 1ns / 100ps

module vector3_arith_unit_core_test;
	import v3au_pkg::*;

	localparam int W = 32;
	localparam int FB = 16;
	localparam int LATENCY = 2 * W + FB + 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 408;

	typedef logic signed [W-1:0] comp_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		comp_t a [3];
		comp_t b [3];
		comp_t k;
	} vec_op_t;

	typedef struct {
		comp_t r [3];
		comp_t s;
		logic eq;
		logic flt;
	} vec_res_t;

	logic clk, arst_n, start, busy, done;
	logic [CMD_W-1:0] command;
	comp_t a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;
	comp_t res_x, res_y, res_z, res_scalar;
	logic is_equal, fault;
	int cycles;

	vector3_arith_unit_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.scalar_in(scalar_in), .done(done), .res_x(res_x), .res_y(res_y),
		.res_z(res_z), .res_scalar(res_scalar), .is_equal(is_equal), .fault(fault)
	);

	class vec_scoreboard;
		vec_res_t pending [$];
		int errors;

		static function comp_t clamp(wide_t v);
			wide_t hi, lo;
			hi = (wide_t'(1) <<< (W - 1)) - 1;
			lo = -(wide_t'(1) <<< (W - 1));
			if (v > hi) return comp_t'(hi);
			if (v < lo) return comp_t'(lo);
			return comp_t'(v);
		endfunction

		static function wide_t root_floor(wide_t x);
			wide_t rem, root, bit_w;
			rem = x;
			root = 0;
			bit_w = wide_t'(1) <<< 62;
			while (bit_w > rem) bit_w = bit_w >>> 2;
			while (bit_w != 0) begin
				if (rem >= root + bit_w) begin
					rem = rem - (root + bit_w);
					root = (root >>> 1) + bit_w;
				end else begin
					root = root >>> 1;
				end
				bit_w = bit_w >>> 2;
			end
			return root;
		endfunction

		static function vec_res_t compute(vec_op_t op);
			vec_res_t r;
			wide_t a [3], b [3], k, len;
			r.r = '{0, 0, 0};
			r.s = 0;
			r.eq = 0;
			r.flt = 0;
			for (int i = 0; i < 3; i++) begin
				a[i] = op.a[i];
				b[i] = op.b[i];
			end
			k = op.k;
			case (op.cmd)
				CMD_ADD: for (int i = 0; i < 3; i++) r.r[i] = clamp(a[i] + b[i]);
				CMD_SUB: for (int i = 0; i < 3; i++) r.r[i] = clamp(a[i] - b[i]);
				CMD_SCALE: for (int i = 0; i < 3; i++) r.r[i] = clamp((a[i] * k) >>> FB);
				CMD_DIVIDE: begin
					if (k == 0) r.flt = 1;
					else for (int i = 0; i < 3; i++) r.r[i] = clamp((a[i] <<< FB) / k);
				end
				CMD_DOT: r.s = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB);
				CMD_CROSS: begin
					r.r[0] = clamp((a[1] * b[2] - a[2] * b[1]) >>> FB);
					r.r[1] = clamp((a[2] * b[0] - a[0] * b[2]) >>> FB);
					r.r[2] = clamp((a[0] * b[1] - a[1] * b[0]) >>> FB);
				end
				CMD_LENGTH: r.s = clamp(root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
				CMD_NORMALIZE: begin
					len = root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
					if (len == 0) r.flt = 1;
					else begin
						for (int i = 0; i < 3; i++) r.r[i] = clamp((a[i] <<< FB) / len);
						r.s = clamp(len);
					end
				end
				CMD_EQUAL: r.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
				default: ;
			endcase
			return r;
		endfunction

		function void note_op(vec_op_t op);
			pending.push_back(compute(op));
		endfunction

		function void report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
			errors++;
			$display("mismatch %s: got %h expected %h", what, got, want);
		endfunction

		function void check_result(vec_res_t got);
			vec_res_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("mismatch: result with no transaction outstanding");
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 3; i++)
				if (got.r[i] !== want.r[i]) report_mismatch($sformatf("res[%0d]", i), got.r[i], want.r[i]);
			if (got.s !== want.s) report_mismatch("res_scalar", got.s, want.s);
			if (got.eq !== want.eq) report_mismatch("is_equal", got.eq, want.eq);
			if (got.flt !== want.flt) report_mismatch("fault", got.flt, want.flt);
		endfunction
	endclass

	vec_scoreboard sb = new();

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vector3_arith_unit_core_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		vec_op_t op;
		vec_res_t got;
		if (arst_n && start && !busy) begin
			op.cmd = command;
			op.a = '{a_x, a_y, a_z};
			op.b = '{b_x, b_y, b_z};
			op.k = scalar_in;
			sb.note_op(op);
		end
		if (arst_n && done) begin
			got.r = '{res_x, res_y, res_z};
			got.s = res_scalar;
			got.eq = is_equal;
			got.flt = fault;
			sb.check_result(got);
		end
	end

	// called at a falling edge, returns at a falling edge after acceptance
	task automatic send_op(vec_op_t op, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start = 0;
			@(negedge clk);
		end
		command = op.cmd;
		{a_x, a_y, a_z} = {op.a[0], op.a[1], op.a[2]};
		{b_x, b_y, b_z} = {op.b[0], op.b[1], op.b[2]};
		scalar_in = op.k;
		start = 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic comp_t rand_comp();
		case ($urandom_range(6))
			0: return comp_t'($urandom);
			1: return {W{1'b1}} << (W - 1);
			2: return ~({W{1'b1}} << (W - 1));
			3: return 0;
			4: return comp_t'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
			5: return comp_t'($signed($urandom_range(2 * 65536 * 300)) - 65536 * 300);
			default: return comp_t'($urandom) >>> $urandom_range(W - 1);
		endcase
	endfunction

	function automatic vec_op_t rand_op();
		vec_op_t op;
		op.cmd = CMD_W'(($urandom_range(19) == 0) ? $urandom_range(15, CMD_EQUAL + 1)
			: $urandom_range(CMD_EQUAL));
		for (int i = 0; i < 3; i++) begin
			op.a[i] = rand_comp();
			op.b[i] = rand_comp();
		end
		op.k = rand_comp();
		// equal vectors and a zero vector are rare in random draws
		if (op.cmd == CMD_EQUAL && $urandom_range(1)) begin
			op.b = op.a;
			if ($urandom_range(2) == 0) op.b[$urandom_range(2)] ^= comp_t'(1) << $urandom_range(W - 1);
		end
		if (op.cmd == CMD_NORMALIZE && $urandom_range(9) == 0) op.a = '{0, 0, 0};
		return op;
	endfunction

	function automatic vec_op_t make_op(logic [CMD_W-1:0] cmd, comp_t a0, comp_t a1, comp_t a2,
		comp_t b0, comp_t b1, comp_t b2, comp_t k);
		vec_op_t op;
		op.cmd = cmd;
		op.a = '{a0, a1, a2};
		op.b = '{b0, b1, b2};
		op.k = k;
		return op;
	endfunction

	initial begin
		comp_t mx, mn;
		int idle_mix [4];
		mx = ~({W{1'b1}} << (W - 1));
		mn = {W{1'b1}} << (W - 1);
		// the receiver cannot stall, so its phase runs the sender flat out
		idle_mix = '{0, 63, 0, 34};
		cycles = 0;
		arst_n = 0;
		start = 0;
		command = CMD_ADD;
		{a_x, a_y, a_z, b_x, b_y, b_z, scalar_in} = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_op(make_op(CMD_ADD, mx, mn, 1, mx, mn, -1, 0), 0);
		send_op(make_op(CMD_SUB, mx, mn, 0, mn, mx, 0, 0), 0);
		send_op(make_op(CMD_SCALE, mx, mn, -3, 0, 0, 0, mn), 0);
		send_op(make_op(CMD_SCALE, 3 << 16, -1, 1, 0, 0, 0, 1 << 15), 0);
		send_op(make_op(CMD_DIVIDE, mx, mn, 7, 0, 0, 0, 0), 0);
		send_op(make_op(CMD_DIVIDE, mx, mn, -7, 0, 0, 0, 1), 0);
		send_op(make_op(CMD_DIVIDE, 1 << 16, -5, 5, 0, 0, 0, 3 << 16), 0);
		send_op(make_op(CMD_DOT, mn, mn, mn, mn, mn, mn, 0), 0);
		send_op(make_op(CMD_DOT, mx, mn, -1, mn, mx, 1, 0), 0);
		send_op(make_op(CMD_CROSS, mx, mn, mx, mn, mx, mn, 0), 0);
		send_op(make_op(CMD_CROSS, 1 << 16, 0, -1, 0, 1 << 16, 3, 0), 0);
		send_op(make_op(CMD_LENGTH, mn, mn, mn, 0, 0, 0, 0), 0);
		send_op(make_op(CMD_LENGTH, 3 << 16, 4 << 16, 0, 0, 0, 0, 0), 0);
		send_op(make_op(CMD_NORMALIZE, 0, 0, 0, 1, 1, 1, 1), 0);
		send_op(make_op(CMD_NORMALIZE, 1, 0, 0, 0, 0, 0, 0), 0);
		send_op(make_op(CMD_NORMALIZE, mn, mx, -1, 0, 0, 0, 0), 0);
		send_op(make_op(CMD_EQUAL, mn, mx, 0, mn, mx, 0, 0), 0);
		send_op(make_op(CMD_EQUAL, mn, mx, 0, mn, mx, 1, 0), 0);
		send_op(make_op(CMD_W'(CMD_EQUAL + 1), mx, mx, mx, mx, mx, mx, 0), 0);
		send_op(make_op(4'hF, mn, mn, mn, mn, mn, mn, 0), 0);

		foreach (idle_mix[p]) begin
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// runs without gaps between idle spells
				send_op(rand_op(), ($urandom_range(7) == 0) ? 0 : idle_mix[p]);
			end
		end
		start = 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("vector3_arith_unit_core_test passed");
		else
			$display("vector3_arith_unit_core_test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/v3au_pkg.sv
src/v3au_sqrt_cell.sv
src/v3au_div_cell.sv
src/vector3_arith_unit_core.sv
tb/vector3_arith_unit_core_test.sv
